// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the moment limiter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dgml_pkg.sv =====
// ----------------------------------------------------------------------------
// DG minmod moment limiter package
// Types, constants and the difference scaling function of the limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dgml_pkg;

	localparam int NCOEF = 4;
	localparam int MAX_MODES = 4;
	localparam int MODE_CAP = (MAX_MODES < NCOEF) ? MAX_MODES : NCOEF;
	localparam int COEF_W = 32;
	localparam int DIFF_W = COEF_W + 1;
	localparam int THRESH_W = 31;
	localparam int MODE_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = THRESH_W;

	localparam logic [THRESH_W-1:0] JUMP_THRESHOLD_RST = 31'd65536;
	localparam logic [MODE_W-1:0] MODES_IN_USE_RST = 3'd3;
	localparam logic [MODE_W-1:0] LOWEST_LIMITED_RST = 3'd1;

	// Reciprocals for unsigned division of a 32-bit value by three and by five.
	localparam logic [COEF_W-1:0] RECIP_3 = 32'hAAAA_AAAB;
	localparam logic [COEF_W-1:0] RECIP_5 = 32'hCCCC_CCCD;
	localparam int RECIP_3_SH = 33;
	localparam int RECIP_5_SH = 34;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_JUMP_THRESHOLD = 2'd0,
		CFG_FORCE_LIMIT    = 2'd1,
		CFG_MODES_IN_USE   = 2'd2,
		CFG_LOWEST_LIMITED = 2'd3
	} cfg_reg_t;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [NCOEF-1:0] cell_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	typedef struct packed {
		cell_t coef;
		logic  first;
		logic  last;
		logic  reduced;
	} item_t;

	typedef struct packed {
		logic use_left;
		logic use_right;
		logic reduced;
	} lim_ctrl_t;

	typedef struct packed {
		cell_t coef;
		logic  end_of_run;
	} result_t;

	// Reduced scaling divides by 2(2j-1), truncating toward zero. The division
	// works on the magnitude: a shift by one, then a reciprocal multiply.
	function automatic diff_t scale_diff(input diff_t d, input int unsigned j,
			input logic reduced);
		diff_t neg;
		logic [COEF_W-1:0] mag;
		logic [COEF_W-1:0] half;
		logic [2*COEF_W-1:0] prod;
		logic [COEF_W-1:0] quo;
		diff_t res;
		neg = -d;
		mag = d[DIFF_W-1] ? neg[COEF_W-1:0] : d[COEF_W-1:0];
		half = mag >> 1;
		prod = '0;
		case (j)
			2: begin
				prod = {{COEF_W{1'b0}}, half} * {{COEF_W{1'b0}}, RECIP_3};
				quo = COEF_W'(prod >> RECIP_3_SH);
			end
			3: begin
				prod = {{COEF_W{1'b0}}, half} * {{COEF_W{1'b0}}, RECIP_5};
				quo = COEF_W'(prod >> RECIP_5_SH);
			end
			default: begin
				quo = half;
			end
		endcase
		res = {1'b0, quo};
		if (d[DIFF_W-1]) begin
			res = -res;
		end
		return reduced ? res : d;
	endfunction

endpackage

// ===== sv/dgml_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input stage
// Registers one cell request and flags it when its potential jump is large or limiting is forced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dgml_in_stage
	import dgml_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cell_t               in_cell,
	input  logic signed [31:0]  potential_left,
	input  logic signed [31:0]  potential_right,
	input  logic                first_cell,
	input  logic                last_cell,
	input  logic [THRESH_W-1:0] jump_threshold,
	input  logic                force_limit,
	input  logic                take,
	output logic                valid_s1,
	output item_t               item_s1
);

	diff_t jump;
	diff_t jump_neg;
	logic [DIFF_W-1:0] jump_mag;
	logic reduced;
	logic load;

	always_comb begin
		jump = diff_t'(potential_left) - diff_t'(potential_right);
		jump_neg = -jump;
		jump_mag = jump[DIFF_W-1] ? jump_neg : jump;
		reduced = force_limit || (jump_mag > {2'b00, jump_threshold});
	end

	assign in_stall = valid_s1 && !take;
	assign load = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.coef <= in_cell;
			item_s1.first <= first_cell;
			item_s1.last <= last_cell;
			item_s1.reduced <= reduced;
		end
	end

endmodule

// ===== sv/dgml_limiter.sv =====
// ----------------------------------------------------------------------------
// Minmod limiter
// Limits the higher modes of one cell against one or both neighbors and clears the modes beyond those in use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dgml_limiter
	import dgml_pkg::*;
(
	input  cell_t             cur_cell,
	input  cell_t             left,
	input  cell_t             right,
	input  lim_ctrl_t         ctrl,
	input  logic [MODE_W-1:0] modes_in_use,
	input  logic [MODE_W-1:0] lowest_limited_mode,
	output cell_t             res
);

	logic [MODE_W-1:0] mode_cnt;
	logic [MODE_W-1:0] low_mode;
	logic interior;

	always_comb begin
		mode_cnt = modes_in_use;
		if (modes_in_use == '0) begin
			mode_cnt = MODE_W'(1);
		end else if (modes_in_use > MODE_W'(MODE_CAP)) begin
			mode_cnt = MODE_W'(MODE_CAP);
		end
		interior = ctrl.use_left && ctrl.use_right;
		low_mode = MODE_W'(1);
		if (interior && lowest_limited_mode != '0) begin
			low_mode = lowest_limited_mode;
		end
	end

	assign res[0] = cur_cell[0];

	for (genvar j = 1; j < NCOEF; j++) begin : g_mode
		diff_t a;
		diff_t dr;
		diff_t dl;
		diff_t r_sel;
		logic pos;
		logic neg;
		coef_t res_j;

		always_comb begin
			a = diff_t'(cur_cell[j]);
			dr = scale_diff(diff_t'(right[j-1]) - diff_t'(cur_cell[j-1]), j,
				ctrl.reduced);
			dl = scale_diff(diff_t'(cur_cell[j-1]) - diff_t'(left[j-1]), j,
				ctrl.reduced);
			pos = (a > 0) && (!ctrl.use_right || dr > 0) && (!ctrl.use_left || dl > 0);
			neg = (a < 0) && (!ctrl.use_right || dr < 0) && (!ctrl.use_left || dl < 0);
			r_sel = a;
			if (pos) begin
				if (ctrl.use_right && dr < r_sel) begin
					r_sel = dr;
				end
				if (ctrl.use_left && dl < r_sel) begin
					r_sel = dl;
				end
			end else if (neg) begin
				if (ctrl.use_right && dr > r_sel) begin
					r_sel = dr;
				end
				if (ctrl.use_left && dl > r_sel) begin
					r_sel = dl;
				end
			end else begin
				r_sel = '0;
			end
			// The chosen value never exceeds the coefficient in magnitude.
			if (MODE_W'(j) >= mode_cnt) begin
				res_j = '0;
			end else if (MODE_W'(j) < low_mode || !(ctrl.use_left || ctrl.use_right)) begin
				res_j = cur_cell[j];
			end else begin
				res_j = r_sel[COEF_W-1:0];
			end
		end

		assign res[j] = res_j;
	end

endmodule

// ===== sv/dgml_out_stage.sv =====
// ----------------------------------------------------------------------------
// Output stage
// Result register that holds a limited cell until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dgml_out_stage
	import dgml_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	output logic    free,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t res_q
);

	assign free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== sv/dg_minmod_moment_limiter.sv =====
// ----------------------------------------------------------------------------
// DG minmod moment limiter
// Takes one DG cell per request, holds each cell that does not close its
// domain until its right neighbor arrives and sends it out with modes 1 and
// up (interior cells: from the lowest limited mode) limited by minmod against
// the scaled mode differences; first and last cells of a domain are limited
// one-sided, and a cell with a large potential jump, or every cell when
// limiting is forced, uses the reduced scale 0.5/(2j-1). A cell enters the
// input register every cycle the input is not stalled; results leave by the
// result register. One shared limiter yields one result per cycle while the
// output is not stalled, so a closing cell after a held neighbor stays in the
// input register for two results; the second takes the first as left neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dg_minmod_moment_limiter
	import dgml_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [31:0]    coef_0,
	input  logic signed [31:0]    coef_1,
	input  logic signed [31:0]    coef_2,
	input  logic signed [31:0]    coef_3,
	input  logic signed [31:0]    potential_left,
	input  logic signed [31:0]    potential_right,
	input  logic                  first_cell,
	input  logic                  last_cell,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    out_coef_0,
	output logic signed [31:0]    out_coef_1,
	output logic signed [31:0]    out_coef_2,
	output logic signed [31:0]    out_coef_3,
	output logic                  end_of_run
);

	logic [THRESH_W-1:0] jump_threshold_q;
	logic force_limit_q;
	logic [MODE_W-1:0] modes_in_use_q;
	logic [MODE_W-1:0] lowest_limited_q;

	cell_t in_cell;
	item_t item_s1;
	logic valid_s1;

	logic phase_q;
	logic held_valid_q;
	logic held_first_q;
	logic held_reduced_q;
	cell_t held_q;
	cell_t left_q;

	logic sel_held;
	logic need_second;
	logic emit;
	logic step;
	logic take;
	logic out_free;
	lim_ctrl_t lim_ctrl;
	cell_t lim_cell;
	cell_t lim_res;
	result_t res_d;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_threshold_q <= JUMP_THRESHOLD_RST;
			force_limit_q <= 1'b0;
			modes_in_use_q <= MODES_IN_USE_RST;
			lowest_limited_q <= LOWEST_LIMITED_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				CFG_JUMP_THRESHOLD: jump_threshold_q <= cfg_data;
				CFG_FORCE_LIMIT:    force_limit_q <= cfg_data[0];
				CFG_MODES_IN_USE:   modes_in_use_q <= cfg_data[MODE_W-1:0];
				CFG_LOWEST_LIMITED: lowest_limited_q <= cfg_data[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_cell[0] = coef_0;
	assign in_cell[1] = coef_1;
	assign in_cell[2] = coef_2;
	assign in_cell[3] = coef_3;

	dgml_in_stage u_in_stage (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_cell         (in_cell),
		.potential_left  (potential_left),
		.potential_right (potential_right),
		.first_cell      (first_cell),
		.last_cell       (last_cell),
		.jump_threshold  (jump_threshold_q),
		.force_limit     (force_limit_q),
		.take            (take),
		.valid_s1        (valid_s1),
		.item_s1         (item_s1)
	);

	always_comb begin
		sel_held = !phase_q && held_valid_q;
		need_second = sel_held && item_s1.last;
		emit = sel_held || item_s1.last;
		step = valid_s1 && (!emit || out_free);
		take = step && !need_second;
		if (sel_held) begin
			lim_cell = held_q;
			lim_ctrl.use_left = !held_first_q;
			lim_ctrl.use_right = !item_s1.first;
			lim_ctrl.reduced = held_reduced_q;
			res_d.end_of_run = item_s1.first;
		end else begin
			lim_cell = item_s1.coef;
			lim_ctrl.use_left = phase_q && !item_s1.first;
			lim_ctrl.use_right = 1'b0;
			lim_ctrl.reduced = item_s1.reduced;
			res_d.end_of_run = 1'b1;
		end
		res_d.coef = lim_res;
	end

	dgml_limiter u_limiter (
		.cur_cell            (lim_cell),
		.left                (left_q),
		.right               (item_s1.coef),
		.ctrl                (lim_ctrl),
		.modes_in_use        (modes_in_use_q),
		.lowest_limited_mode (lowest_limited_q),
		.res                 (lim_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			held_valid_q <= 1'b0;
			held_first_q <= 1'b0;
			held_reduced_q <= 1'b0;
		end else if (step) begin
			phase_q <= need_second;
			if (!phase_q) begin
				held_valid_q <= !item_s1.last;
				if (!item_s1.last) begin
					held_first_q <= item_s1.first || !sel_held;
					held_reduced_q <= item_s1.reduced;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !phase_q && !item_s1.last) begin
			held_q <= item_s1.coef;
		end
		if (step && (sel_held || phase_q) && !item_s1.first) begin
			left_q <= lim_res;
		end
	end

	dgml_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && emit),
		.res_in    (res_d),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign out_coef_0 = res_q.coef[0];
	assign out_coef_1 = res_q.coef[1];
	assign out_coef_2 = res_q.coef[2];
	assign out_coef_3 = res_q.coef[3];
	assign end_of_run = res_q.end_of_run;

	`ASSERT_IMPL(a_phase_item, clk, arst_n, phase_q, valid_s1 && item_s1.last && !held_valid_q, "Second result pending without a closing cell in the input register.")
	`ASSERT_NEXT(a_phase_once, clk, arst_n, phase_q && step, !phase_q, "A cell produced more than two results.")
	`ASSERT_NEXT(a_hold_taken, clk, arst_n, step && !phase_q && !item_s1.last, held_valid_q, "A cell that does not close its domain was not held.")

endmodule
